@@ hdl/prfs_pkg.sv @@
package prfs_pkg;

  // Ring geometry
  localparam int unsigned RingSlots    = 16;
  localparam int unsigned PayloadBytes = 512;
  localparam int unsigned SlotWords    = (PayloadBytes + 7) / 8;
  localparam int unsigned PtrW         = $clog2(RingSlots);
  localparam int unsigned OccW         = $clog2(RingSlots + 1);
  localparam int unsigned PayDepth     = RingSlots * SlotWords;
  localparam int unsigned PayAddrW     = $clog2(PayDepth);

  // Field widths
  localparam int unsigned ActW  = 2;
  localparam int unsigned CodeW = 2;
  localparam int unsigned IdxW  = 6;
  localparam int unsigned WordW = 64;
  localparam int unsigned LenW  = 10;
  localparam int unsigned SrcW  = 32;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CntW  = 32;
  localparam int unsigned NwW   = 8;
  localparam int unsigned MetaW = LenW + SrcW + TimeW;

  typedef enum logic [ActW-1:0] {
    ACT_WRITE   = 2'd0,
    ACT_COMMIT  = 2'd1,
    ACT_DEQUEUE = 2'd2,
    ACT_STATUS  = 2'd3
  } action_e;

  typedef enum logic [CodeW-1:0] {
    CODE_OK      = 2'd0,
    CODE_BAD_LEN = 2'd1,
    CODE_FULL    = 2'd2,
    CODE_EMPTY   = 2'd3
  } code_e;

  typedef enum logic {
    ST_IDLE,
    ST_STREAM
  } state_e;

  typedef struct packed {
    logic commit;
    logic drop;
    logic dequeue;
  } stats_ev_t;

  typedef struct packed {
    logic [PtrW-1:0] head;
    logic [PtrW-1:0] tail;
    logic [OccW-1:0] occ;
    logic [OccW-1:0] hw;
    logic [CntW-1:0] drops;
    logic [CntW-1:0] processed;
  } stats_t;

  typedef struct packed {
    logic [LenW-1:0]  len;
    logic [SrcW-1:0]  src;
    logic [TimeW-1:0] rx_time;
  } meta_t;

  // Flat payload address of one word in one slot
  function automatic logic [PayAddrW-1:0] word_addr(logic [PtrW-1:0] slot,
                                                     logic [IdxW-1:0] idx);
    return PayAddrW'(slot) * PayAddrW'(SlotWords) + PayAddrW'(idx);
  endfunction

  // Words to stream for a packet: ceil(len/8), at least one, at most a slot
  function automatic logic [NwW-1:0] num_words(logic [LenW-1:0] len);
    logic [NwW-1:0] n;
    n = NwW'((LenW'(len) + (LenW + 1)'(7)) >> 3);
    if (n == '0) begin
      n = NwW'(1);
    end
    if (n > NwW'(SlotWords)) begin
      n = NwW'(SlotWords);
    end
    return n;
  endfunction

endpackage

@@ hdl/prfs_ram.sv @@
module prfs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/prfs_stats.sv @@
module prfs_stats (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  prfs_pkg::stats_ev_t ev_i,
  output prfs_pkg::stats_t    stats_o
);

  import prfs_pkg::*;

  stats_t stats_d, stats_q;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(RingSlots - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    stats_d = stats_q;
    priority if (ev_i.commit) begin
      stats_d.head = ptr_inc(stats_q.head);
      stats_d.occ  = stats_q.occ + OccW'(1);
      if (stats_q.occ + OccW'(1) > stats_q.hw) begin
        stats_d.hw = stats_q.occ + OccW'(1);
      end
    end else if (ev_i.dequeue) begin
      stats_d.tail      = ptr_inc(stats_q.tail);
      stats_d.occ       = stats_q.occ - OccW'(1);
      stats_d.processed = stats_q.processed + CntW'(1);
    end else if (ev_i.drop) begin
      stats_d.drops = stats_q.drops + CntW'(1);
    end else begin
      // hold
      stats_d = stats_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stats_q <= '0;
    end else begin
      stats_q <= stats_d;
    end
  end

  assign stats_o = stats_q;

endmodule

@@ hdl/packet_ring_fifo_with_stats_unit.sv @@
// Channel  Handshake                Word
// in       in_valid_i / in_stall_o    action, word index, data, length, source, time
// out      out_valid_o / out_stall_i  code, data word, index, length, source, time,
//                                     last, occupancy, peak occupancy, drops, processed
//
// Write, commit and status give one word, as does a dequeue of an empty ring.
// Dequeue first reads the tail slot, then streams ceil(length/8) words
// (at least one), one per unstalled cycle from the single payload RAM read port.
// Reset clears pointers and counters at once; RAM contents are left as they are.
// A stalled output holds its word and the payload RAM read; input stalls meanwhile.
module packet_ring_fifo_with_stats_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [prfs_pkg::ActW-1:0]     action_i,
  input  logic [prfs_pkg::IdxW-1:0]     word_index_i,
  input  logic [prfs_pkg::WordW-1:0]    word_data_i,
  input  logic [prfs_pkg::LenW-1:0]     length_i,
  input  logic [prfs_pkg::SrcW-1:0]     source_address_i,
  input  logic [prfs_pkg::TimeW-1:0]    received_time_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [prfs_pkg::CodeW-1:0]    code_o,
  output logic [prfs_pkg::WordW-1:0]    data_word_o,
  output logic [prfs_pkg::IdxW-1:0]     out_word_index_o,
  output logic [prfs_pkg::LenW-1:0]     out_length_o,
  output logic [prfs_pkg::SrcW-1:0]     out_source_address_o,
  output logic [prfs_pkg::TimeW-1:0]    out_received_time_o,
  output logic                          last_o,
  output logic [prfs_pkg::OccW-1:0]     occupancy_o,
  output logic [prfs_pkg::OccW-1:0]     peak_occupancy_o,
  output logic [prfs_pkg::CntW-1:0]     drop_count_o,
  output logic [prfs_pkg::CntW-1:0]     processed_count_o
);

  import prfs_pkg::*;

  typedef struct packed {
    code_e             code;
    logic [WordW-1:0]  data;
    logic [IdxW-1:0]   idx;
    logic [LenW-1:0]   len;
    logic [SrcW-1:0]   src;
    logic [TimeW-1:0]  rx_time;
    logic              last;
  } result_t;

  state_e  state_d, state_q;
  result_t res_d, res_q;
  logic    out_valid_d, out_valid_q;
  logic [IdxW-1:0] idx_d, idx_q;
  logic [PtrW-1:0] slot_d, slot_q;

  stats_ev_t ev;
  stats_t    stats;

  logic                pay_we, pay_re;
  logic [PayAddrW-1:0] pay_waddr, pay_raddr;
  logic [WordW-1:0]    pay_rdata;
  logic                meta_we, meta_re;
  logic [MetaW-1:0]    meta_rdata;
  meta_t               meta_wr, meta_rd;

  action_e        action;
  logic           full, empty, in_acc, out_free, stream_load, is_last;
  logic           idx_ok, len_ok;
  logic [NwW-1:0] nwords;

  assign action   = action_e'(action_i);
  assign full     = stats.occ >= OccW'(RingSlots);
  assign empty    = stats.occ == '0;
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign idx_ok = (IdxW + 1)'(word_index_i) < (IdxW + 1)'(SlotWords);
  assign len_ok = (LenW + 1)'(length_i) <= (LenW + 1)'(PayloadBytes);

  assign meta_wr = '{len: length_i, src: source_address_i, rx_time: received_time_i};
  assign meta_rd = meta_t'(meta_rdata);

  assign nwords      = num_words(meta_rd.len);
  assign is_last     = (NwW'(idx_q) + NwW'(1)) == nwords;
  assign stream_load = (state_q == ST_STREAM) && out_free;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && action == ACT_DEQUEUE && !empty) begin
          state_d = ST_STREAM;
        end
      end
      ST_STREAM: begin
        if (out_free && is_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory commands and counter events
  always_comb begin
    ev        = '0;
    pay_we    = 1'b0;
    pay_waddr = word_addr(stats.head, word_index_i);
    pay_re    = 1'b0;
    pay_raddr = word_addr(stats.tail, '0);
    meta_we   = 1'b0;
    meta_re   = 1'b0;
    if (in_acc) begin
      unique case (action)
        ACT_WRITE: begin
          pay_we = !full && idx_ok;
        end
        ACT_COMMIT: begin
          if (len_ok) begin
            ev.drop   = full;
            ev.commit = !full;
            meta_we   = !full;
          end
        end
        ACT_DEQUEUE: begin
          if (!empty) begin
            ev.dequeue = 1'b1;
            pay_re     = 1'b1;
            meta_re    = 1'b1;
          end
        end
        ACT_STATUS: begin
        end
        default: begin
        end
      endcase
    end
    // Fetch the next word while the current one moves to the output
    if (stream_load && !is_last) begin
      pay_re    = 1'b1;
      pay_raddr = word_addr(slot_q, idx_q + IdxW'(1));
    end
  end

  // Output register and stream position
  always_comb begin
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    idx_d       = idx_q;
    slot_d      = slot_q;
    if (in_acc) begin
      if (action == ACT_DEQUEUE && !empty) begin
        idx_d  = '0;
        slot_d = stats.tail;
      end else begin
        res_d       = '0;
        res_d.last  = 1'b1;
        out_valid_d = 1'b1;
        unique case (action)
          ACT_WRITE:   res_d.code = full ? CODE_FULL : CODE_OK;
          ACT_COMMIT:  res_d.code = !len_ok ? CODE_BAD_LEN : (full ? CODE_FULL : CODE_OK);
          ACT_DEQUEUE: res_d.code = CODE_EMPTY;
          ACT_STATUS:  res_d.code = CODE_OK;
          default:     res_d.code = CODE_OK;
        endcase
      end
    end
    if (stream_load) begin
      res_d.code    = CODE_OK;
      res_d.data    = pay_rdata;
      res_d.idx     = idx_q;
      res_d.len     = meta_rd.len;
      res_d.src     = meta_rd.src;
      res_d.rx_time = meta_rd.rx_time;
      res_d.last    = is_last;
      out_valid_d   = 1'b1;
      if (!is_last) begin
        idx_d = idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    idx_q  <= idx_d;
    slot_q <= slot_d;
  end

  prfs_stats u_stats (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ev_i    (ev),
    .stats_o (stats)
  );

  // One item at a time: a read never overlaps a write to the same entry
  prfs_ram #(
    .Width (WordW),
    .Depth (PayDepth)
  ) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (pay_waddr),
    .wdata_i (word_data_i),
    .re_i    (pay_re),
    .raddr_i (pay_raddr),
    .rdata_o (pay_rdata)
  );

  prfs_ram #(
    .Width (MetaW),
    .Depth (RingSlots)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (stats.head),
    .wdata_i (meta_wr),
    .re_i    (meta_re),
    .raddr_i (stats.tail),
    .rdata_o (meta_rdata)
  );

  assign out_valid_o          = out_valid_q;
  assign code_o               = res_q.code;
  assign data_word_o          = res_q.data;
  assign out_word_index_o     = res_q.idx;
  assign out_length_o         = res_q.len;
  assign out_source_address_o = res_q.src;
  assign out_received_time_o  = res_q.rx_time;
  assign last_o               = res_q.last;
  assign occupancy_o          = stats.occ;
  assign peak_occupancy_o     = stats.hw;
  assign drop_count_o         = stats.drops;
  assign processed_count_o    = stats.processed;

endmodule

@@ hdl/prfs_checker.sv @@
module prfs_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic [prfs_pkg::ActW-1:0]  action_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [prfs_pkg::CodeW-1:0] code_o,
  input logic [prfs_pkg::WordW-1:0] data_word_o,
  input logic                       last_o,
  input logic [prfs_pkg::OccW-1:0]  occupancy_o,
  input logic [prfs_pkg::OccW-1:0]  peak_occupancy_o
);

  import prfs_pkg::*;

  // Stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(data_word_o) && $stable(last_o))
    else $error("stalled output word changed");

  // Single-word actions answer in the next cycle with last set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && action_i != ACT_DEQUEUE |=> out_valid_o && last_o)
    else $error("single-word action did not answer at once");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occupancy_o <= OccW'(RingSlots) && peak_occupancy_o >= occupancy_o)
    else $error("occupancy out of range or above peak occupancy");

  // An empty answer only when nothing is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && code_o == CODE_EMPTY |-> occupancy_o == '0)
    else $error("empty code while packets are held");

endmodule

bind packet_ring_fifo_with_stats_unit prfs_checker u_prfs_checker (.*);
